### sv/edd_pkg.sv
// Shared types and constants for the 1-bit error-diffusion dither.
// No dependencies; every other file of the block but edd_ram uses it.
`timescale 1ns / 1ps

package edd_pkg;

  localparam int PIX_W      = 8;   // gray pixel
  localparam int LVL_W      = 8;   // output level registers
  localparam int RW_W       = 10;  // row width register
  localparam int ERR_W      = 10;  // stored error, signed
  localparam int SUM_W      = 14;  // neighbor sum, signed
  localparam int INT_W      = 12;  // corrected intensity and raw error, signed
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic signed [INT_W-1:0] ERR_MIN = -12'sd512;
  localparam logic signed [INT_W-1:0] ERR_MAX = 12'sd511;
  localparam logic [LVL_W:0]          LVL_FULL = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_HIGH = 2'd0,
    CFG_LEVEL_LOW  = 2'd1,
    CFG_INVERT     = 2'd2,
    CFG_ROW_WIDTH  = 2'd3
  } cfg_idx_e;

  // Effective levels after the "high of zero" rule.
  typedef struct packed {
    logic [LVL_W:0]   hi;
    logic [LVL_W-1:0] lo;
    logic [LVL_W:0]   thr;
    logic             invert;
  } levels_t;

  // Neighbor errors, already masked at the image and row edges.
  typedef struct packed {
    logic signed [ERR_W-1:0] ul;
    logic signed [ERR_W-1:0] up;
    logic signed [ERR_W-1:0] ur;
    logic signed [ERR_W-1:0] lf;
  } nbr_t;

  // One dithered bit handed to the packer.
  typedef struct packed {
    logic vld;
    logic dbit;
    logic last;
  } pk_ctrl_t;

endpackage

### sv/edd_pix_if.sv
// Pixel input channel: valid/ready with the gray pixel and first-row flag.
// Uses edd_pkg for the payload width.
`timescale 1ns / 1ps

interface edd_pix_if;
  logic                     valid;
  logic                     ready;
  logic [edd_pkg::PIX_W-1:0] pixel;
  logic                     first_row;

  modport source (output valid, output pixel, output first_row, input ready);
  modport sink   (input valid, input pixel, input first_row, output ready);
endinterface

### sv/edd_byte_if.sv
// Packed output channel: valid/ready with eight dithered bits and row end.
// Uses edd_pkg for the payload width.
`timescale 1ns / 1ps

interface edd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [edd_pkg::BYTE_W-1:0] packed_bits;
  logic                      row_end;

  modport source (output valid, output packed_bits, output row_end, input ready);
  modport sink   (input valid, input packed_bits, input row_end, output ready);
endinterface

### sv/edd_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module edd_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### sv/edd_err_calc.sv
// Error stage arithmetic: weighted neighbor sum, threshold decision, new error.
// Depends on edd_pkg.
`timescale 1ns / 1ps

module edd_err_calc (
  input  edd_pkg::levels_t                    lvl_i,
  input  edd_pkg::nbr_t                       nbr_i,
  input  logic [edd_pkg::PIX_W-1:0]           pixel_i,
  output logic signed [edd_pkg::ERR_W-1:0]    err_o,
  output logic                                bit_o
);

  logic signed [edd_pkg::SUM_W-1:0] ul_x, up_x, ur_x, lf_x, up_lf, sum;
  logic signed [edd_pkg::INT_W-1:0] inten, thr_x, hi_x, lo_x, diff;
  logic                             bright;

  always_comb begin
    ul_x  = edd_pkg::SUM_W'(nbr_i.ul);
    up_x  = edd_pkg::SUM_W'(nbr_i.up);
    ur_x  = edd_pkg::SUM_W'(nbr_i.ur);
    lf_x  = edd_pkg::SUM_W'(nbr_i.lf);
    up_lf = up_x + lf_x;
    sum   = ul_x + ur_x + (up_lf <<< 1) + up_lf;

    // arithmetic shift gives the floor of sum / 8
    inten = edd_pkg::INT_W'(sum >>> 3)
          + $signed({{(edd_pkg::INT_W-edd_pkg::PIX_W){1'b0}}, pixel_i});
    thr_x = $signed({{(edd_pkg::INT_W-edd_pkg::LVL_W-1){1'b0}}, lvl_i.thr});
    hi_x  = $signed({{(edd_pkg::INT_W-edd_pkg::LVL_W-1){1'b0}}, lvl_i.hi});
    lo_x  = $signed({{(edd_pkg::INT_W-edd_pkg::LVL_W){1'b0}}, lvl_i.lo});

    bright = (inten >= thr_x);
    diff   = bright ? (inten - hi_x) : (inten - lo_x);

    if (diff < edd_pkg::ERR_MIN) begin
      err_o = edd_pkg::ERR_W'(edd_pkg::ERR_MIN);
    end else if (diff > edd_pkg::ERR_MAX) begin
      err_o = edd_pkg::ERR_W'(edd_pkg::ERR_MAX);
    end else begin
      err_o = edd_pkg::ERR_W'(diff);
    end

    bit_o = bright ? lvl_i.invert : ~lvl_i.invert;
  end

endmodule

### sv/edd_packer.sv
// Bit packer and output register: gathers bits MSB-first, flushes on row end.
// Depends on edd_pkg and edd_byte_if.
`timescale 1ns / 1ps

module edd_packer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  edd_pkg::pk_ctrl_t ctl_i,
  output logic              take_o,
  edd_byte_if.source        byte_o
);

  logic [edd_pkg::BYTE_W-1:0] acc_q, acc_n, out_bits_q;
  logic [edd_pkg::CNT_W-1:0]  cnt_q;
  logic [edd_pkg::CNT_W:0]    cnt_n, sh;
  logic                       out_vld_q, out_end_q;
  logic                       emit, ld;

  assign acc_n = {acc_q[edd_pkg::BYTE_W-2:0], ctl_i.dbit};
  assign cnt_n = {1'b0, cnt_q} + 1'b1;
  assign sh    = (edd_pkg::CNT_W+1)'(edd_pkg::BYTE_W) - cnt_n;
  assign emit  = ctl_i.last || (cnt_q == {edd_pkg::CNT_W{1'b1}});
  // a bit that completes a byte needs the output register free
  assign take_o = !emit || !out_vld_q || byte_o.ready;
  assign ld     = ctl_i.vld && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (ctl_i.vld) begin
        if (emit) begin
          acc_q <= '0;
          cnt_q <= '0;
        end else begin
          acc_q <= acc_n;
          cnt_q <= edd_pkg::CNT_W'(cnt_n);
        end
      end
      if (ld) begin
        out_vld_q <= 1'b1;
      end else if (byte_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      out_bits_q <= acc_n << sh;   // left-align a partial byte
      out_end_q  <= ctl_i.last;
    end
  end

  assign byte_o.valid       = out_vld_q;
  assign byte_o.packed_bits = out_bits_q;
  assign byte_o.row_end     = out_end_q;

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld |=> (cnt_q == '0) && (acc_q == '0))
    else $error("packer state not cleared after byte transfer");

endmodule

### sv/error_diffusion_dither_1bit_unit.sv
// 1-bit error-diffusion dither, top level. Depends on edd_pkg, edd_pix_if,
// edd_byte_if, edd_ram, edd_err_calc and edd_packer.
//
//   channel   dir  handshake       payload
//   pix_i     in   valid / ready   pixel[7:0], first_row
//   byte_o    out  valid / ready   packed_bits[7:0], row_end
//   cfg       in   cfg_we_i        cfg_idx_i[1:0], cfg_wdata_i[9:0]
//
// One pixel per clock while no stall holds the input. A pixel is accepted, its
// column's two line errors are read from the line RAM into registers, and the
// error stage then closes the left-error loop, writes the new error back and
// hands a bit to the packer; a byte is loaded into the output register when
// its last pixel's bit is handed over. Back-to-back line accesses are covered by forwarding
// the last write. Reset clears control state only; the line RAM holds nothing
// valid until a first row has been written (no clearing pass). The input
// stalls only while a byte-completing pixel waits on a full output register.
`timescale 1ns / 1ps

module error_diffusion_dither_1bit_unit #(
  parameter int ROW_MAX = 512
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [edd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [edd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  edd_pix_if.sink                          pix_i,
  edd_byte_if.source                       byte_o
);

  localparam int COL_W = $clog2(ROW_MAX);
  localparam int WID_W = $clog2(ROW_MAX + 1);
  localparam int CMP_W = (WID_W > edd_pkg::RW_W) ? WID_W : edd_pkg::RW_W;

  // configuration
  logic [edd_pkg::LVL_W-1:0] level_high_q, level_low_q;
  logic                      invert_q;
  logic [edd_pkg::RW_W-1:0]  row_width_q;
  edd_pkg::levels_t          lvl;
  logic [CMP_W-1:0]          rw_x, eff_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_high_q <= '0;
      level_low_q  <= '0;
      invert_q     <= 1'b0;
      row_width_q  <= 10'd512;
    end else if (cfg_we_i) begin
      case (edd_pkg::cfg_idx_e'(cfg_idx_i))
        edd_pkg::CFG_LEVEL_HIGH: level_high_q <= cfg_wdata_i[edd_pkg::LVL_W-1:0];
        edd_pkg::CFG_LEVEL_LOW:  level_low_q  <= cfg_wdata_i[edd_pkg::LVL_W-1:0];
        edd_pkg::CFG_INVERT:     invert_q     <= cfg_wdata_i[0];
        edd_pkg::CFG_ROW_WIDTH:  row_width_q  <= cfg_wdata_i[edd_pkg::RW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (level_high_q == '0) begin
      lvl.hi = edd_pkg::LVL_FULL;
      lvl.lo = '0;
    end else begin
      lvl.hi = {1'b0, level_high_q};
      lvl.lo = level_low_q;
    end
    lvl.thr    = (edd_pkg::LVL_W+1)'(({1'b0, lvl.hi} + (edd_pkg::LVL_W+2)'(lvl.lo)) >> 1);
    lvl.invert = invert_q;

    rw_x = CMP_W'(row_width_q);
    if (rw_x == '0) begin
      eff_w = CMP_W'(1);
    end else if (rw_x > CMP_W'(ROW_MAX)) begin
      eff_w = CMP_W'(ROW_MAX);
    end else begin
      eff_w = rw_x;
    end
  end

  // issue stage: column counter and line RAM reads
  logic [COL_W-1:0] col_a_q, rb_a;
  logic [CMP_W-1:0] col_a_inc;
  logic             last_a, accept;

  assign accept    = pix_i.valid && pix_i.ready;
  assign col_a_inc = CMP_W'(col_a_q) + 1'b1;
  assign last_a    = (col_a_inc >= eff_w);
  assign rb_a      = last_a ? col_a_q : COL_W'(col_a_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_a_q <= '0;
    end else if (accept) begin
      col_a_q <= last_a ? '0 : COL_W'(col_a_inc);
    end
  end

  // error stage
  logic                          vld_b_q, last_b_q, first_b_q, b_go, col0_b, take;
  logic [COL_W-1:0]              col_b_q, rb_b_q;
  logic [edd_pkg::PIX_W-1:0]     pix_b_q;
  logic signed [edd_pkg::ERR_W-1:0] ul_q, left_q, err, up_raw, ur_raw;
  logic [edd_pkg::ERR_W-1:0]     rdata_a, rdata_b;
  logic                          wr_vld_q;
  logic [COL_W-1:0]              wr_addr_q;
  logic signed [edd_pkg::ERR_W-1:0] wr_data_q;
  logic                          dbit;
  edd_pkg::nbr_t                 nbr;
  edd_pkg::pk_ctrl_t             pk_ctl;

  assign b_go        = vld_b_q && take;
  assign pix_i.ready = !vld_b_q || b_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q  <= 1'b0;
      ul_q     <= '0;
      left_q   <= '0;
      wr_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        vld_b_q <= 1'b1;
      end else if (b_go) begin
        vld_b_q <= 1'b0;
      end
      if (b_go) begin
        ul_q     <= nbr.up;
        left_q   <= err;
        wr_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_b_q   <= col_a_q;
      rb_b_q    <= rb_a;
      last_b_q  <= last_a;
      first_b_q <= pix_i.first_row;
      pix_b_q   <= pix_i.pixel;
    end
    if (b_go) begin
      wr_addr_q <= col_b_q;
      wr_data_q <= err;
    end
  end

  edd_ram #(
    .WIDTH (edd_pkg::ERR_W),
    .DEPTH (ROW_MAX)
  ) u_line (
    .clk_i     (clk_i),
    .we_i      (b_go),
    .waddr_i   (col_b_q),
    .wdata_i   (err),
    .re_i      (accept),
    .raddr_a_i (col_a_q),
    .raddr_b_i (rb_a),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // the RAM returns old data when the previous pixel wrote the same entry
  always_comb begin
    up_raw = (wr_vld_q && (wr_addr_q == col_b_q)) ? wr_data_q : $signed(rdata_a);
    ur_raw = (wr_vld_q && (wr_addr_q == rb_b_q))  ? wr_data_q : $signed(rdata_b);
    col0_b = (col_b_q == '0);
    nbr.up = first_b_q ? '0 : up_raw;
    nbr.ur = (first_b_q || last_b_q) ? '0 : ur_raw;
    nbr.ul = (first_b_q || col0_b) ? '0 : ul_q;
    nbr.lf = col0_b ? '0 : left_q;
  end

  edd_err_calc u_calc (
    .lvl_i   (lvl),
    .nbr_i   (nbr),
    .pixel_i (pix_b_q),
    .err_o   (err),
    .bit_o   (dbit)
  );

  assign pk_ctl.vld  = b_go;
  assign pk_ctl.dbit = dbit;
  assign pk_ctl.last = last_b_q;

  edd_packer u_pack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (pk_ctl),
    .take_o (take),
    .byte_o (byte_o)
  );

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_a) |=> (col_a_q == '0))
    else $error("column did not wrap after last pixel of row");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (vld_b_q && byte_o.valid && !byte_o.ready))
    else $error("input stalled without a blocked output");

endmodule
